/* rtl/stb_pkg.sv */
`timescale 1ns / 1ps

package stb_pkg;

  localparam int CNT_W = 16;
  localparam int IDX_W = 3;
  localparam int REQ_W = 2;
  localparam int ADDR_SPAN = 1 << IDX_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_POLL = 2'd2,
    REQ_READ = 2'd3
  } req_e;

  typedef struct packed {
    logic             tick;
    logic             set;
    logic             poll;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] stop;
  } stb_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             elapsed;
    logic             elapsed_old;
    logic             running;
  } stb_view_t;

endpackage

/* rtl/stb_if.sv */
`timescale 1ns / 1ps

interface stb_in_if;
  import stb_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] timer_index;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] load_limit;

  modport source (output valid, req_type, timer_index, load_count, load_limit,
                  input ready);
  modport sink (input valid, req_type, timer_index, load_count, load_limit,
                output ready);
endinterface

interface stb_out_if;
  import stb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_value;
  logic             elapsed_flag;
  logic             running_flag;

  modport source (output valid, count_value, elapsed_flag, running_flag,
                  input ready);
  modport sink (input valid, count_value, elapsed_flag, running_flag,
                output ready);
endinterface

/* rtl/stb_cell.sv */
`timescale 1ns / 1ps

module stb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                sel,
  input  stb_pkg::stb_cmd_t   cmd,
  output stb_pkg::stb_view_t  view
);
  import stb_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic             run_r, run_nxt;
  logic             ela_r, ela_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    lim_nxt = lim_r;
    run_nxt = run_r;
    ela_nxt = ela_r;
    if (cmd.tick && run_r) begin
      if (cnt_r >= lim_r) begin
        run_nxt = 1'b0;
        ela_nxt = 1'b1;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
    if (sel && cmd.set) begin
      cnt_nxt = cmd.start;
      lim_nxt = cmd.stop;
      run_nxt = 1'b1;
      ela_nxt = 1'b0;
    end
    if (sel && cmd.poll) begin
      ela_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lim_r <= '0;
      run_r <= 1'b0;
      ela_r <= 1'b0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
      lim_r <= lim_nxt;
      run_r <= run_nxt;
      ela_r <= ela_nxt;
    end
  end

  assign view.count       = cnt_nxt;
  assign view.elapsed     = ela_nxt;
  assign view.elapsed_old = ela_r;
  assign view.running     = run_nxt;

endmodule

/* rtl/soft_timer_bank.sv */
`timescale 1ns / 1ps

// Bank of NUM_TIMERS 16-bit up-counting timers.
// in_ch carries requests: tick (advance every running timer), set (load
// count and threshold, start, clear elapsed), poll (report and clear
// elapsed) and read (report only). Timers 0..7 are addressable; every
// timer ticks. A request to an absent timer reports all-zero fields.
// Every accepted request yields exactly one transfer on out_ch, carrying
// the addressed timer's count, elapsed and running flags after the request
// (poll reports elapsed before clearing).
// The result is valid in the cycle after the request transfer.
// Throughput: one request per cycle unless out_ch stalls; each request is
// one parallel timer bank update plus one registered result stage.
// When out_ch stalls, the held result stays in the output register and
// in_ch.ready drops until it is taken; no request is lost.
// Reset (rst_n low, synchronous) clears all counts, thresholds, running
// and elapsed flags and empties the output register.
module soft_timer_bank #(
  parameter int NUM_TIMERS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  stb_in_if.sink    in_ch,
  stb_out_if.source out_ch
);
  import stb_pkg::*;

  logic      in_acc;
  logic      out_valid_r;
  stb_cmd_t  cmd;
  stb_view_t view [NUM_TIMERS];
  stb_view_t view_a [ADDR_SPAN];
  stb_view_t hit;
  logic      present;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ela_r, ela_nxt;
  logic             run_r, run_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cmd.tick  = (req_e'(in_ch.req_type) == REQ_TICK);
  assign cmd.set   = (req_e'(in_ch.req_type) == REQ_SET);
  assign cmd.poll  = (req_e'(in_ch.req_type) == REQ_POLL);
  assign cmd.start = in_ch.load_count;
  assign cmd.stop  = in_ch.load_limit;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    localparam bit ADDR_OK = (i < ADDR_SPAN);
    logic sel;
    assign sel = ADDR_OK && (32'(in_ch.timer_index) == i);
    stb_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (in_acc),
      .sel   (sel),
      .cmd   (cmd),
      .view  (view[i])
    );
  end

  for (genvar j = 0; j < ADDR_SPAN; j++) begin : g_addr
    if (j < NUM_TIMERS) begin : g_on
      assign view_a[j] = view[j];
    end else begin : g_off
      assign view_a[j] = '0;
    end
  end

  assign hit     = view_a[in_ch.timer_index];
  assign present = (32'(in_ch.timer_index) < NUM_TIMERS);

  always_comb begin
    cnt_nxt = '0;
    ela_nxt = 1'b0;
    run_nxt = 1'b0;
    if (present) begin
      cnt_nxt = hit.count;
      ela_nxt = cmd.poll ? hit.elapsed_old : hit.elapsed;
      run_nxt = hit.running;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r <= cnt_nxt;
      ela_r <= ela_nxt;
      run_r <= run_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.count_value  = cnt_r;
  assign out_ch.elapsed_flag = ela_r;
  assign out_ch.running_flag = run_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_ch.valid)
    else $error("request transfer without result");

  a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd.set && present) |=>
      (out_ch.running_flag && !out_ch.elapsed_flag &&
       out_ch.count_value == $past(in_ch.load_count)))
    else $error("set result mismatch");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !present) |=>
      (out_ch.count_value == '0 && !out_ch.elapsed_flag && !out_ch.running_flag))
    else $error("absent timer result not zero");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_acc)
    else $error("request taken while result stalled");

endmodule
